// File: rtl/csp_pkg.sv
package csp_pkg;

	localparam int AddrW         = 32;
	localparam int CidW          = 16;
	localparam int CfgW          = 32;
	localparam int CfgIdxW       = 3;
	localparam int CID_WIDTH_DEF = 16;

	typedef enum logic [2:0] {
		ST_CLOSED  = 3'd0,
		ST_LISTEN  = 3'd1,
		ST_WAITING = 3'd2,
		ST_ESTAB   = 3'd3,
		ST_DISCONN = 3'd4
	} state_t;

	typedef enum logic [2:0] {
		K_DATA = 3'd0,
		K_REQ  = 3'd1,
		K_ACC  = 3'd2,
		K_ACK  = 3'd3,
		K_FIN  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		V_DROP  = 2'd0,
		V_DONE  = 2'd1,
		V_OWN   = 2'd2,
		V_ENDED = 2'd3
	} verdict_t;

	typedef enum logic [CfgIdxW-1:0] {
		R_LOCAL_ADDR  = 3'd0,
		R_LOCAL_CID   = 3'd1,
		R_OPEN_MODE   = 3'd2,
		R_PRESET_ADDR = 3'd3,
		R_PRESET_CID  = 3'd4
	} reg_idx_t;

	// open_mode codes
	localparam logic [1:0] OM_CLOSED  = 2'd0;
	localparam logic [1:0] OM_LISTEN  = 2'd1;
	localparam logic [1:0] OM_WAITING = 2'd2;

	typedef struct packed {
		logic [4:0]      pad;
		logic            sink_closed;
		logic [CidW-1:0] dst_cid;
		logic [CidW-1:0] src_cid;
		logic [AddrW-1:0] dst_addr;
		logic [AddrW-1:0] src_addr;
		logic            checksum_ok;
		logic            header_ok;
	} in_word_t;

	typedef struct packed {
		logic     pad;
		state_t   conn_state;
		logic     with_conn_info;
		logic     forward_payload;
		verdict_t verdict;
	} res_t;

	typedef struct packed {
		state_t           state;
		logic [AddrW-1:0] local_addr;
		logic [CidW-1:0]  local_cid;
		logic [AddrW-1:0] peer_addr;
		logic [CidW-1:0]  peer_cid;
	} conn_t;

	typedef struct packed {
		logic   set_state;
		state_t next_state;
		logic   learn;
		logic   clear;
	} upd_t;

endpackage

// File: rtl/csp_decide.sv
module csp_decide import csp_pkg::*; #(
	parameter int CID_WIDTH = CID_WIDTH_DEF
) (
	input  in_word_t item,
	input  logic [2:0] kind_raw,
	input  conn_t    conn,
	output res_t     res,
	output upd_t     upd
);

	localparam int CmpW = (CID_WIDTH < CidW) ? CID_WIDTH : CidW;

	kind_t kind;
	logic  scid_l, dcid_l, scid_p, src_l, dst_l, src_p;
	logic  own, own_fin, peer_match;
	state_t nxt;

	assign kind   = (kind_raw > K_FIN) ? K_DATA : kind_t'(kind_raw);
	assign scid_l = item.src_cid[CmpW-1:0] == conn.local_cid[CmpW-1:0];
	assign dcid_l = item.dst_cid[CmpW-1:0] == conn.local_cid[CmpW-1:0];
	assign scid_p = item.src_cid[CmpW-1:0] == conn.peer_cid[CmpW-1:0];
	assign src_l  = item.src_addr == conn.local_addr;
	assign dst_l  = item.dst_addr == conn.local_addr;
	assign src_p  = item.src_addr == conn.peer_addr;

	assign own        = (item.src_addr != item.dst_addr) && src_l && scid_l && (kind != K_FIN);
	assign own_fin    = src_l && scid_l && (kind == K_FIN);
	assign peer_match = src_p && dst_l && scid_p && dcid_l;

	always_comb begin
		res     = '0;
		upd     = '0;
		upd.next_state = conn.state;
		if (!item.header_ok || !item.checksum_ok) begin
			res.verdict = V_DROP;
		end else if (own) begin
			res.verdict = V_OWN;
		end else begin
			case (conn.state)
				ST_ESTAB: begin
					if (kind == K_REQ || kind == K_ACC) begin
						res.verdict = V_DROP;
					end else if (own_fin) begin
						upd.set_state  = 1'b1;
						upd.next_state = ST_DISCONN;
					end else if (peer_match) begin
						res.forward_payload = 1'b1;
						upd.clear   = item.sink_closed || (kind == K_FIN);
						res.verdict = (kind == K_FIN) ? V_ENDED : V_DONE;
					end
				end
				ST_LISTEN: begin
					if (kind == K_REQ && dst_l && dcid_l) begin
						upd.learn          = 1'b1;
						upd.set_state      = 1'b1;
						upd.next_state     = ST_ESTAB;
						res.forward_payload = 1'b1;
						res.with_conn_info  = 1'b1;
						res.verdict        = V_DONE;
					end
				end
				ST_WAITING: begin
					if (kind == K_ACC && peer_match) begin
						upd.set_state      = 1'b1;
						upd.next_state     = ST_ESTAB;
						res.forward_payload = 1'b1;
						res.verdict        = V_DONE;
					end
				end
				ST_DISCONN: begin
					if (kind == K_ACK && peer_match) begin
						upd.clear          = 1'b1;
						res.forward_payload = 1'b1;
						res.verdict        = V_ENDED;
					end
				end
				default: begin
					res.verdict = V_DROP;
				end
			endcase
		end
		nxt = upd.clear ? ST_CLOSED : upd.next_state;
		res.conn_state = nxt;
	end

endmodule

// File: rtl/csp_conn_regs.sv
module csp_conn_regs import csp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgW-1:0]     cfg_data,
	input  logic                step,
	input  upd_t                upd,
	input  logic [AddrW-1:0]    learn_addr,
	input  logic [CidW-1:0]     learn_cid,
	output conn_t               conn
);

	state_t           state_q;
	logic [AddrW-1:0] local_addr_q, peer_addr_q;
	logic [CidW-1:0]  local_cid_q, peer_cid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLOSED;
			local_addr_q <= '0;
			local_cid_q  <= '0;
			peer_addr_q  <= '0;
			peer_cid_q   <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				R_LOCAL_ADDR:  local_addr_q <= cfg_data[AddrW-1:0];
				R_LOCAL_CID:   local_cid_q  <= cfg_data[CidW-1:0];
				R_OPEN_MODE: begin
					case (cfg_data[1:0])
						OM_LISTEN:  state_q <= ST_LISTEN;
						OM_WAITING: state_q <= ST_WAITING;
						default:    state_q <= ST_CLOSED;
					endcase
				end
				R_PRESET_ADDR: peer_addr_q  <= cfg_data[AddrW-1:0];
				R_PRESET_CID:  peer_cid_q   <= cfg_data[CidW-1:0];
				default: ;
			endcase
		end else if (step) begin
			if (upd.clear) begin
				state_q      <= ST_CLOSED;
				local_addr_q <= '0;
				local_cid_q  <= '0;
				peer_addr_q  <= '0;
				peer_cid_q   <= '0;
			end else begin
				if (upd.set_state)
					state_q <= upd.next_state;
				if (upd.learn) begin
					peer_addr_q <= learn_addr;
					peer_cid_q  <= learn_cid;
				end
			end
		end
	end

	assign conn.state      = state_q;
	assign conn.local_addr = local_addr_q;
	assign conn.local_cid  = local_cid_q;
	assign conn.peer_addr  = peer_addr_q;
	assign conn.peer_cid   = peer_cid_q;

endmodule

// File: rtl/connection_state_on_packet_unit.sv
// Per-connection packet decision unit. Each input word is one parsed header;
// each output word is its verdict, forward/info flags and the connection
// state after the header. Registers: input, result. One header is taken
// every cycle unless the output stalls; the state update is done in the
// same cycle a header moves into the result register, so consecutive
// headers see each other's effect. Configuration writes are meant for idle
// periods; an open_mode write sets the state, preset writes load the peer.
module connection_state_on_packet_unit import csp_pkg::*; #(
	parameter int CID_WIDTH = CID_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	// header_ok, checksum_ok, src_addr, dst_addr, src_cid, dst_cid, sink_closed
	input  logic [103:0]       s_tdata,
	// pkt_kind
	input  logic [2:0]         s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	// verdict, forward_payload, with_conn_info, conn_state
	output logic [7:0]         m_tdata,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data
);

	in_word_t   item_s1;
	logic [2:0] kind_s1;
	logic       valid_s1;
	res_t       res_q;
	logic       valid_q;

	res_t  res;
	upd_t  upd;
	conn_t conn;
	logic  out_free, step;

	assign out_free = !valid_q || m_tready;
	assign step     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (out_free)
				valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= in_word_t'(s_tdata);
			kind_s1 <= s_tuser;
		end
		if (step)
			res_q <= res;
	end

	csp_decide #(.CID_WIDTH(CID_WIDTH)) u_decide (
		.item     (item_s1),
		.kind_raw (kind_s1),
		.conn     (conn),
		.res      (res),
		.upd      (upd)
	);

	csp_conn_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.step       (step),
		.upd        (upd),
		.learn_addr (item_s1.src_addr),
		.learn_cid  (item_s1.src_cid),
		.conn       (conn)
	);

	assign m_tvalid = valid_q;
	assign m_tdata  = res_q;

endmodule
